### sv/tagged_datagram_field_parser_assert.svh
// assertion macros used by the port-level checker file
`ifndef TAGGED_DATAGRAM_FIELD_PARSER_ASSERT_SVH
`define TAGGED_DATAGRAM_FIELD_PARSER_ASSERT_SVH

// same-cycle implication
`define TDFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tdfp_pkg.sv
// types, codes and field schedule rom for the datagram field parser
package tdfp_pkg;

    localparam logic [31:0] MAGIC_WORD  = 32'hADBCCBDA;
    localparam logic [31:0] NULL_LENGTH = 32'hFFFFFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  field_index;
        logic [63:0] value;
        logic [1:0]  schema_seen;
        logic [2:0]  error_code;
        logic        last;
    } t_out_beat;

    typedef enum logic [2:0] {
        K_HEADER   = 3'd0,
        K_NUMBER   = 3'd1,
        K_STR_LEN  = 3'd2,
        K_NULL_STR = 3'd3,
        K_STR_BYTE = 3'd4,
        K_END      = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        E_OK         = 3'd0,
        E_TRUNC      = 3'd1,
        E_BAD_MAGIC  = 3'd2,
        E_BAD_SCHEMA = 3'd3,
        E_BAD_TYPE   = 3'd4,
        E_TRAILING   = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        P_MAGIC  = 3'd0,
        P_SCHEMA = 3'd1,
        P_TYPE   = 3'd2,
        P_NUM    = 3'd3,
        P_SLEN   = 3'd4,
        P_SBYTE  = 3'd5,
        P_DONE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        FT_U32  = 3'd0,
        FT_U64  = 3'd1,
        FT_U8   = 3'd2,
        FT_BOOL = 3'd3,
        FT_DBL  = 3'd4,
        FT_STR  = 3'd5
    } t_ftype;

    function automatic logic [4:0] field_count(input logic [1:0] mt);
        logic [4:0] cnt;
        case (mt)
            2'd0:    cnt = 5'd4;
            2'd1:    cnt = 5'd22;
            2'd2:    cnt = 5'd10;
            default: cnt = 5'd0;
        endcase
        return cnt;
    endfunction

    function automatic t_ftype field_type(input logic [1:0] mt, input logic [4:0] pos);
        t_ftype ft;
        ft = FT_U32;
        case (mt)
            2'd0: begin
                case (pos) inside
                    5'd0, 5'd2, 5'd3: ft = FT_STR;
                    default:          ft = FT_U32;
                endcase
            end
            2'd1: begin
                case (pos) inside
                    5'd0, 5'd2, 5'd3, 5'd4, 5'd5, 5'd11, 5'd12, 5'd13,
                    5'd15, 5'd20, 5'd21:               ft = FT_STR;
                    5'd1:                              ft = FT_U64;
                    5'd6, 5'd7, 5'd8, 5'd14, 5'd16:    ft = FT_BOOL;
                    5'd17:                             ft = FT_U8;
                    default:                           ft = FT_U32;
                endcase
            end
            2'd2: begin
                case (pos) inside
                    5'd0, 5'd6, 5'd7:  ft = FT_STR;
                    5'd1, 5'd8, 5'd9:  ft = FT_BOOL;
                    5'd4:              ft = FT_DBL;
                    default:           ft = FT_U32;
                endcase
            end
            default: ft = FT_U32;
        endcase
        return ft;
    endfunction

    function automatic t_phase entry_phase(input logic [1:0] mt, input logic [4:0] pos);
        t_phase ph;
        if (pos >= field_count(mt)) begin
            ph = P_DONE;
        end else if (field_type(mt, pos) == FT_STR) begin
            ph = P_SLEN;
        end else begin
            ph = P_NUM;
        end
        return ph;
    endfunction

endpackage

### sv/tagged_datagram_field_parser.sv
// top level of the tagged datagram field parser
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+----------------------------
//  bytes in | i_valid | o_ready | i_data  (t_in_beat)
//  results  | o_valid | i_ready | o_data  (t_out_beat)
//
// one byte is taken per cycle while o_ready is high; results come from r_in via the buffer
// a byte that yields two results (field plus end status) takes both result buffer entries
// throughput is set by the two-entry result buffer behind the parse logic
// synchronous active-low reset returns the parser to awaiting the magic word
// a stalled output fills the buffer, then the input register, then drops o_ready
module tagged_datagram_field_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tdfp_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tdfp_pkg::t_out_beat  o_data
);

    logic                r_in_valid;
    tdfp_pkg::t_in_beat  r_in;
    logic                fire;
    logic                fits;
    logic                pop;
    logic [1:0]          need;
    tdfp_pkg::t_out_beat res0;
    tdfp_pkg::t_out_beat res1;

    assign pop     = o_valid & i_ready;
    assign fire    = r_in_valid & fits;
    assign o_ready = ~r_in_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    tdfp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_need  (need),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    tdfp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_need  (need),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_pop   (pop),
        .o_fits  (fits),
        .o_valid (o_valid),
        .o_head  (o_data)
    );

endmodule

### sv/tdfp_core.sv
// parse state and per-byte result logic
module tdfp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  tdfp_pkg::t_in_beat   i_item,
    output logic [1:0]           o_need,
    output tdfp_pkg::t_out_beat  o_res0,
    output tdfp_pkg::t_out_beat  o_res1
);

    tdfp_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_bif, n_bif;
    logic [63:0]      r_acc, n_acc;
    logic [4:0]       r_pos, n_pos;
    logic [1:0]       r_mtype, n_mtype;
    logic [1:0]       r_schema, n_schema;
    logic [31:0]      r_rem, n_rem;
    logic             r_drop, n_drop;

    tdfp_pkg::t_err     err;
    tdfp_pkg::t_ftype   ft;
    tdfp_pkg::t_out_beat data_res;
    tdfp_pkg::t_out_beat end_res;
    logic               has_data;
    logic               has_end;
    logic [63:0]        acc_sh;
    logic [3:0]         bif_inc;
    logic [3:0]         fwidth;
    logic [31:0]        word;
    logic [31:0]        rem_dec;
    logic [4:0]         pos_inc;
    logic               eod;

    always_comb begin
        acc_sh   = {r_acc[55:0], i_item.data_byte};
        bif_inc  = r_bif + 4'd1;
        word     = acc_sh[31:0];
        rem_dec  = r_rem - 32'd1;
        pos_inc  = r_pos + 5'd1;
        eod      = i_item.end_of_datagram;
        ft       = tdfp_pkg::field_type(r_mtype, r_pos);
        case (ft)
            tdfp_pkg::FT_U64, tdfp_pkg::FT_DBL: fwidth = 4'd8;
            tdfp_pkg::FT_U32:                   fwidth = 4'd4;
            default:                            fwidth = 4'd1;
        endcase

        n_phase  = r_phase;
        n_bif    = r_bif;
        n_acc    = r_acc;
        n_pos    = r_pos;
        n_mtype  = r_mtype;
        n_schema = r_schema;
        n_rem    = r_rem;
        n_drop   = r_drop;
        err      = tdfp_pkg::E_OK;
        has_data = 1'b0;
        has_end  = 1'b0;
        data_res = '0;
        end_res  = '0;
        end_res.kind = tdfp_pkg::K_END;
        end_res.last = 1'b1;

        if (!r_drop) begin
            unique case (r_phase)
                tdfp_pkg::P_NUM: begin
                    n_acc = acc_sh;
                    n_bif = bif_inc;
                    if (bif_inc >= fwidth) begin
                        has_data             = 1'b1;
                        data_res.kind        = tdfp_pkg::K_NUMBER;
                        data_res.field_index = r_pos;
                        data_res.value       = (ft == tdfp_pkg::FT_BOOL) ?
                                               {63'd0, |acc_sh} : acc_sh;
                        n_pos   = pos_inc;
                        n_bif   = '0;
                        n_acc   = '0;
                        n_phase = tdfp_pkg::entry_phase(r_mtype, pos_inc);
                    end
                end
                tdfp_pkg::P_SLEN: begin
                    n_acc = acc_sh;
                    n_bif = bif_inc;
                    if (bif_inc >= 4'd4) begin
                        has_data             = 1'b1;
                        data_res.field_index = r_pos;
                        n_bif                = '0;
                        n_acc                = '0;
                        if (word == tdfp_pkg::NULL_LENGTH) begin
                            data_res.kind = tdfp_pkg::K_NULL_STR;
                            n_pos   = pos_inc;
                            n_phase = tdfp_pkg::entry_phase(r_mtype, pos_inc);
                        end else begin
                            data_res.kind  = tdfp_pkg::K_STR_LEN;
                            data_res.value = {32'd0, word};
                            if (word == 32'd0) begin
                                n_pos   = pos_inc;
                                n_phase = tdfp_pkg::entry_phase(r_mtype, pos_inc);
                            end else begin
                                n_rem   = word;
                                n_phase = tdfp_pkg::P_SBYTE;
                            end
                        end
                    end
                end
                tdfp_pkg::P_SBYTE: begin
                    has_data             = 1'b1;
                    data_res.kind        = tdfp_pkg::K_STR_BYTE;
                    data_res.field_index = r_pos;
                    data_res.value       = {56'd0, i_item.data_byte};
                    n_rem                = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_pos   = pos_inc;
                        n_bif   = '0;
                        n_acc   = '0;
                        n_phase = tdfp_pkg::entry_phase(r_mtype, pos_inc);
                    end
                end
                tdfp_pkg::P_DONE: begin
                    err = tdfp_pkg::E_TRAILING;
                end
                default: begin
                    // magic, schema and type words
                    n_acc = acc_sh;
                    n_bif = bif_inc;
                    if (bif_inc >= 4'd4) begin
                        n_bif = '0;
                        n_acc = '0;
                        if (r_phase == tdfp_pkg::P_SCHEMA) begin
                            if (word != 32'd2 && word != 32'd3) begin
                                err = tdfp_pkg::E_BAD_SCHEMA;
                            end else begin
                                n_schema = word[1:0];
                                n_phase  = tdfp_pkg::P_TYPE;
                            end
                        end else if (r_phase == tdfp_pkg::P_TYPE) begin
                            if (word > 32'd2) begin
                                err = tdfp_pkg::E_BAD_TYPE;
                            end else begin
                                n_mtype              = word[1:0];
                                has_data             = 1'b1;
                                data_res.kind        = tdfp_pkg::K_HEADER;
                                data_res.value       = {32'd0, word};
                                data_res.schema_seen = r_schema;
                                n_pos   = '0;
                                n_phase = tdfp_pkg::entry_phase(word[1:0], 5'd0);
                            end
                        end else begin
                            if (word != tdfp_pkg::MAGIC_WORD) begin
                                err = tdfp_pkg::E_BAD_MAGIC;
                            end else begin
                                n_phase = tdfp_pkg::P_SCHEMA;
                            end
                        end
                    end
                end
            endcase

            if (err != tdfp_pkg::E_OK) begin
                has_end            = 1'b1;
                end_res.error_code = err;
                n_drop             = ~eod;
            end else if (eod) begin
                has_end            = 1'b1;
                end_res.error_code = (n_phase == tdfp_pkg::P_DONE) ?
                                     tdfp_pkg::E_OK : tdfp_pkg::E_TRUNC;
            end
        end

        if (eod) begin
            n_phase  = tdfp_pkg::P_MAGIC;
            n_bif    = '0;
            n_acc    = '0;
            n_pos    = '0;
            n_mtype  = '0;
            n_schema = '0;
            n_rem    = '0;
            n_drop   = 1'b0;
        end

        o_need = {1'b0, has_data} + {1'b0, has_end};
        o_res0 = has_data ? data_res : end_res;
        o_res1 = end_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tdfp_pkg::P_MAGIC;
            r_bif    <= '0;
            r_acc    <= '0;
            r_pos    <= '0;
            r_mtype  <= '0;
            r_schema <= '0;
            r_rem    <= '0;
            r_drop   <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_bif    <= n_bif;
            r_acc    <= n_acc;
            r_pos    <= n_pos;
            r_mtype  <= n_mtype;
            r_schema <= n_schema;
            r_rem    <= n_rem;
            r_drop   <= n_drop;
        end
    end

endmodule

### sv/tdfp_obuf.sv
// two-entry result buffer whose head entry drives the output
module tdfp_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [1:0]           i_need,
    input  tdfp_pkg::t_out_beat  i_res0,
    input  tdfp_pkg::t_out_beat  i_res1,
    input  logic                 i_pop,
    output logic                 o_fits,
    output logic                 o_valid,
    output tdfp_pkg::t_out_beat  o_head
);

    logic [1:0]          r_cnt, n_cnt;
    tdfp_pkg::t_out_beat r_q0, n_q0;
    tdfp_pkg::t_out_beat r_q1, n_q1;
    logic [1:0]          cnt_pop;
    logic [2:0]          cnt_sum;

    always_comb begin
        cnt_pop = r_cnt - {1'b0, i_pop};
        cnt_sum = {1'b0, cnt_pop} + {1'b0, i_need};
        o_fits  = (cnt_sum <= 3'd2);
        n_q0    = i_pop ? r_q1 : r_q0;
        n_q1    = r_q1;
        n_cnt   = cnt_pop;
        if (i_push) begin
            n_cnt = cnt_sum[1:0];
            if (cnt_pop == 2'd0) begin
                n_q0 = i_res0;
                n_q1 = i_res1;
            end else if (cnt_pop == 2'd1) begin
                n_q1 = i_res0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_q0;

endmodule

### sv/tdfp_checker.sv
// port-level checks for the tagged datagram field parser, bound to the top level
`include "tagged_datagram_field_parser_assert.svh"

module tdfp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input tdfp_pkg::t_in_beat   i_data,
    input logic                 o_valid,
    input logic                 i_ready,
    input tdfp_pkg::t_out_beat  o_data
);

    logic in_beat;

    assign in_beat = i_valid & o_ready & i_data.end_of_datagram;

    `TDFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready), (o_valid && $stable(o_data)), "result beat changed while stalled")

    `TDFP_ASSERT_NOW(a_last_is_end, i_clk, i_rst_n, (o_valid || in_beat), (!o_valid || (o_data.last == (o_data.kind == tdfp_pkg::K_END))), "last flag not tied to end status")

    `TDFP_ASSERT_NOW(a_err_on_end, i_clk, i_rst_n, (o_valid && o_data.kind != tdfp_pkg::K_END), (o_data.error_code == tdfp_pkg::E_OK), "error code on a non-end beat")

    `TDFP_ASSERT_NOW(a_header_ok, i_clk, i_rst_n, (o_valid && o_data.kind == tdfp_pkg::K_HEADER), ((o_data.schema_seen == 2'd2 || o_data.schema_seen == 2'd3) && o_data.value <= 64'd2), "header beat with bad schema or type")

endmodule

bind tagged_datagram_field_parser tdfp_checker u_tdfp_checker (.*);

### verif/tdfp_scoreboard_pkg.sv
// scoreboard class: byte-level parse prediction and result comparison for the datagram parser
package tdfp_scoreboard_pkg;

    class parse_scoreboard;

        tdfp_pkg::t_ftype    sched[3][22];
        logic [4:0]          n_fields[3];
        tdfp_pkg::t_out_beat results_due[$];

        tdfp_pkg::t_phase    phase;
        logic [3:0]          byte_cnt;
        logic [63:0]         acc;
        logic [4:0]          fpos;
        logic [1:0]          mtype;
        logic [1:0]          schema;
        logic [31:0]         remaining;
        logic                dropping;

        int n_fail;
        int n_results;
        int end_counts[8];

        function new();
            sched[0] = '{0: tdfp_pkg::FT_STR, 1: tdfp_pkg::FT_U32, 2: tdfp_pkg::FT_STR,
                         3: tdfp_pkg::FT_STR, default: tdfp_pkg::FT_U32};
            sched[1] = '{tdfp_pkg::FT_STR, tdfp_pkg::FT_U64, tdfp_pkg::FT_STR,
                         tdfp_pkg::FT_STR, tdfp_pkg::FT_STR, tdfp_pkg::FT_STR,
                         tdfp_pkg::FT_BOOL, tdfp_pkg::FT_BOOL, tdfp_pkg::FT_BOOL,
                         tdfp_pkg::FT_U32, tdfp_pkg::FT_U32, tdfp_pkg::FT_STR,
                         tdfp_pkg::FT_STR, tdfp_pkg::FT_STR, tdfp_pkg::FT_BOOL,
                         tdfp_pkg::FT_STR, tdfp_pkg::FT_BOOL, tdfp_pkg::FT_U8,
                         tdfp_pkg::FT_U32, tdfp_pkg::FT_U32, tdfp_pkg::FT_STR,
                         tdfp_pkg::FT_STR};
            sched[2] = '{0: tdfp_pkg::FT_STR, 1: tdfp_pkg::FT_BOOL, 2: tdfp_pkg::FT_U32,
                         3: tdfp_pkg::FT_U32, 4: tdfp_pkg::FT_DBL, 5: tdfp_pkg::FT_U32,
                         6: tdfp_pkg::FT_STR, 7: tdfp_pkg::FT_STR, 8: tdfp_pkg::FT_BOOL,
                         9: tdfp_pkg::FT_BOOL, default: tdfp_pkg::FT_U32};
            n_fields[0] = 5'd4;
            n_fields[1] = 5'd22;
            n_fields[2] = 5'd10;
            n_fail = 0;
            n_results = 0;
            foreach (end_counts[k]) end_counts[k] = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase     = tdfp_pkg::P_MAGIC;
            byte_cnt  = '0;
            acc       = '0;
            fpos      = '0;
            mtype     = '0;
            schema    = '0;
            remaining = '0;
            dropping  = 1'b0;
        endfunction

        function void start_field();
            byte_cnt = '0;
            acc      = '0;
            if (fpos >= n_fields[mtype]) begin
                phase = tdfp_pkg::P_DONE;
            end else begin
                phase = (sched[mtype][fpos] == tdfp_pkg::FT_STR) ?
                        tdfp_pkg::P_SLEN : tdfp_pkg::P_NUM;
            end
        endfunction

        function void advance_field();
            fpos = fpos + 5'd1;
            start_field();
        endfunction

        function void push_result(tdfp_pkg::t_kind k, logic [4:0] idx, logic [63:0] v,
                                  logic [1:0] sch, tdfp_pkg::t_err e, logic fin);
            tdfp_pkg::t_out_beat r;
            r.kind        = k;
            r.field_index = idx;
            r.value       = v;
            r.schema_seen = sch;
            r.error_code  = e;
            r.last        = fin;
            results_due.push_back(r);
        endfunction

        // one accepted input beat
        function void parse_byte(tdfp_pkg::t_in_beat beat);
            tdfp_pkg::t_err   err;
            logic [31:0]      word;
            int               width;
            tdfp_pkg::t_ftype ft;
            err = tdfp_pkg::E_OK;
            if (dropping) begin
                if (beat.end_of_datagram) clear_state();
                return;
            end
            case (phase)
                tdfp_pkg::P_MAGIC, tdfp_pkg::P_SCHEMA, tdfp_pkg::P_TYPE: begin
                    acc      = {acc[55:0], beat.data_byte};
                    byte_cnt = byte_cnt + 4'd1;
                    if (byte_cnt >= 4'd4) begin
                        word     = acc[31:0];
                        byte_cnt = '0;
                        acc      = '0;
                        if (phase == tdfp_pkg::P_MAGIC) begin
                            if (word != tdfp_pkg::MAGIC_WORD) err = tdfp_pkg::E_BAD_MAGIC;
                            else phase = tdfp_pkg::P_SCHEMA;
                        end else if (phase == tdfp_pkg::P_SCHEMA) begin
                            if (word != 32'd2 && word != 32'd3) begin
                                err = tdfp_pkg::E_BAD_SCHEMA;
                            end else begin
                                schema = word[1:0];
                                phase  = tdfp_pkg::P_TYPE;
                            end
                        end else if (word > 32'd2) begin
                            err = tdfp_pkg::E_BAD_TYPE;
                        end else begin
                            mtype = word[1:0];
                            push_result(tdfp_pkg::K_HEADER, 5'd0, 64'(word), schema,
                                        tdfp_pkg::E_OK, 1'b0);
                            fpos = '0;
                            start_field();
                        end
                    end
                end
                tdfp_pkg::P_NUM: begin
                    ft       = sched[mtype][fpos];
                    width    = (ft == tdfp_pkg::FT_U64 || ft == tdfp_pkg::FT_DBL) ? 8 :
                               (ft == tdfp_pkg::FT_U32) ? 4 : 1;
                    acc      = {acc[55:0], beat.data_byte};
                    byte_cnt = byte_cnt + 4'd1;
                    if (int'(byte_cnt) >= width) begin
                        push_result(tdfp_pkg::K_NUMBER, fpos,
                                    (ft == tdfp_pkg::FT_BOOL) ? 64'(acc != 0) : acc,
                                    2'd0, tdfp_pkg::E_OK, 1'b0);
                        advance_field();
                    end
                end
                tdfp_pkg::P_SLEN: begin
                    acc      = {acc[55:0], beat.data_byte};
                    byte_cnt = byte_cnt + 4'd1;
                    if (byte_cnt >= 4'd4) begin
                        word = acc[31:0];
                        if (word == tdfp_pkg::NULL_LENGTH) begin
                            push_result(tdfp_pkg::K_NULL_STR, fpos, 64'd0, 2'd0,
                                        tdfp_pkg::E_OK, 1'b0);
                            advance_field();
                        end else begin
                            push_result(tdfp_pkg::K_STR_LEN, fpos, 64'(word), 2'd0,
                                        tdfp_pkg::E_OK, 1'b0);
                            if (word == 32'd0) begin
                                advance_field();
                            end else begin
                                remaining = word;
                                byte_cnt  = '0;
                                acc       = '0;
                                phase     = tdfp_pkg::P_SBYTE;
                            end
                        end
                    end
                end
                tdfp_pkg::P_SBYTE: begin
                    push_result(tdfp_pkg::K_STR_BYTE, fpos, 64'(beat.data_byte), 2'd0,
                                tdfp_pkg::E_OK, 1'b0);
                    remaining = remaining - 32'd1;
                    if (remaining == 32'd0) advance_field();
                end
                default: begin
                    err = tdfp_pkg::E_TRAILING;
                end
            endcase
            if (err != tdfp_pkg::E_OK) begin
                push_result(tdfp_pkg::K_END, 5'd0, 64'd0, 2'd0, err, 1'b1);
                if (beat.end_of_datagram) clear_state();
                else dropping = 1'b1;
            end else if (beat.end_of_datagram) begin
                push_result(tdfp_pkg::K_END, 5'd0, 64'd0, 2'd0,
                            (phase == tdfp_pkg::P_DONE) ? tdfp_pkg::E_OK : tdfp_pkg::E_TRUNC,
                            1'b1);
                clear_state();
            end
        endfunction

        function void check_result(tdfp_pkg::t_out_beat got);
            tdfp_pkg::t_out_beat want;
            bit                  bad;
            n_results++;
            if (got.kind == tdfp_pkg::K_END) end_counts[got.error_code]++;
            if (results_due.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("unexpected result beat: kind %0d idx %0d value %h err %0d last %0d",
                             got.kind, got.field_index, got.value, got.error_code, got.last);
                end
                return;
            end
            want = results_due.pop_front();
            bad  = (got.kind !== want.kind) || (got.field_index !== want.field_index) ||
                   (got.value !== want.value) || (got.schema_seen !== want.schema_seen) ||
                   (got.error_code !== want.error_code) || (got.last !== want.last);
            if (bad) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("mismatch at result %0d: expected kind %0d idx %0d value %h sch %0d err %0d last %0d",
                             n_results, want.kind, want.field_index, want.value,
                             want.schema_seen, want.error_code, want.last);
                    $display("                      actual   kind %0d idx %0d value %h sch %0d err %0d last %0d",
                             got.kind, got.field_index, got.value,
                             got.schema_seen, got.error_code, got.last);
                end
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction

    endclass

endpackage

### verif/tagged_datagram_field_parser_test.sv
// testbench top for the tagged datagram field parser: random frames, stalls and result checks
module tagged_datagram_field_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTES_WANTED = 750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    localparam int FRAME_GOOD   = 0;
    localparam int FRAME_TRUNC  = 1;
    localparam int FRAME_TRAIL  = 2;
    localparam int FRAME_BADHDR = 3;
    localparam int FRAME_NOISE  = 4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    tdfp_pkg::t_in_beat  i_data;
    logic                o_valid;
    logic                i_ready;
    tdfp_pkg::t_out_beat o_data;

    tdfp_scoreboard_pkg::parse_scoreboard sb;
    logic [7:0]      frame_q[$];
    logic            send_burst = 1'b0;
    int              bytes_sent = 0;
    int              frames_sent = 0;
    int              idle_cycles = 0;

    tagged_datagram_field_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.parse_byte(i_data);
            if (o_valid && i_ready) sb.check_result(o_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results still due",
                     IDLE_LIMIT, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls with occasional stretches of none
    initial begin
        int   stall;
        logic recv_burst;
        recv_burst = 1'b0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic void put_byte(logic [7:0] b);
        frame_q.push_back(b);
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int k = 3; k >= 0; k--) put_byte(w[8*k +: 8]);
    endfunction

    function automatic void put_random(int n);
        for (int k = 0; k < n; k++) put_byte(8'($urandom));
    endfunction

    // returns 1 when the length is too big to finish, so the frame ends here
    function automatic bit put_string();
        int          pick;
        logic [31:0] len;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            put_word(tdfp_pkg::NULL_LENGTH);
            return 1'b0;
        end
        if (pick < 5) begin
            put_word(32'd0);
            return 1'b0;
        end
        if (pick == 5) begin
            len = $urandom() | 32'h0100_0000;
            if (len == tdfp_pkg::NULL_LENGTH) len = 32'h8000_0000;
            put_word(len);
            put_random($urandom_range(0, 3));
            return 1'b1;
        end
        len = $urandom_range(1, 6);
        put_word(len);
        put_random(int'(len));
        return 1'b0;
    endfunction

    function automatic void build_frame(logic [1:0] mt, logic [1:0] schema);
        int r;
        bit cut;
        cut = 1'b0;
        frame_q.delete();
        put_word(tdfp_pkg::MAGIC_WORD);
        put_word({30'd0, schema});
        put_word({30'd0, mt});
        for (int i = 0; i < int'(sb.n_fields[mt]) && !cut; i++) begin
            case (sb.sched[mt][i])
                tdfp_pkg::FT_U64, tdfp_pkg::FT_DBL: put_random(8);
                tdfp_pkg::FT_U32:                   put_random(4);
                tdfp_pkg::FT_U8:                    put_random(1);
                tdfp_pkg::FT_BOOL: begin
                    r = $urandom_range(0, 3);
                    put_byte((r == 0) ? 8'h00 : (r == 1) ? 8'h01 : 8'($urandom));
                end
                default: cut = put_string();
            endcase
        end
    endfunction

    task automatic send_beat(tdfp_pkg::t_in_beat beat);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_frame();
        tdfp_pkg::t_in_beat beat;
        for (int k = 0; k < frame_q.size(); k++) begin
            beat.data_byte       = frame_q[k];
            beat.end_of_datagram = (k == frame_q.size() - 1);
            send_beat(beat);
        end
        bytes_sent  += frame_q.size();
        frames_sent++;
    endtask

    initial begin
        int         mode;
        int         pick;
        int         pos;
        int         keep;
        logic [1:0] mt;
        logic [1:0] schema;

        sb = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bad magic with a dropped beat after it
        frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_frame();
        // bad schema completing on the final beat
        frame_q.delete();
        put_word(tdfp_pkg::MAGIC_WORD);
        put_word(32'd0);
        send_frame();
        // unknown type completing on the final beat
        frame_q.delete();
        put_word(tdfp_pkg::MAGIC_WORD);
        put_word(32'd3);
        put_word(32'hFFFF_FFFF);
        send_frame();
        // single beat, cut inside the magic word
        frame_q = '{8'h00};
        send_frame();

        while (bytes_sent < BYTES_WANTED) begin
            if (frames_sent < 9) begin
                mode = frames_sent - 4;
            end else begin
                pick = $urandom_range(0, 99);
                mode = (pick < 45) ? FRAME_GOOD : (pick < 65) ? FRAME_TRUNC :
                       (pick < 75) ? FRAME_TRAIL : (pick < 90) ? FRAME_BADHDR : FRAME_NOISE;
            end
            mt     = (frames_sent < 7) ? 2'(frames_sent - 4) : 2'($urandom_range(0, 2));
            schema = 2'($urandom_range(2, 3));
            build_frame(mt, schema);
            case (mode)
                FRAME_TRUNC: begin
                    keep = $urandom_range(1, frame_q.size() - 1);
                    while (frame_q.size() > keep) void'(frame_q.pop_back());
                end
                FRAME_TRAIL: begin
                    put_random($urandom_range(1, 3));
                end
                FRAME_BADHDR: begin
                    pos = $urandom_range(0, 11);
                    frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
                    keep = $urandom_range(pos + 1, frame_q.size());
                    while (frame_q.size() > keep) void'(frame_q.pop_back());
                end
                FRAME_NOISE: begin
                    frame_q.delete();
                    put_random($urandom_range(1, 8));
                end
                default: ;
            endcase
            send_burst = ($urandom_range(0, 3) == 0);
            send_frame();
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d datagrams, checked %0d results, %0d mismatches",
                 bytes_sent, frames_sent, sb.n_results, sb.n_fail);
        $display("end status seen: ok %0d, truncated %0d, bad magic %0d, bad schema %0d, bad type %0d, trailing %0d",
                 sb.end_counts[tdfp_pkg::E_OK], sb.end_counts[tdfp_pkg::E_TRUNC],
                 sb.end_counts[tdfp_pkg::E_BAD_MAGIC], sb.end_counts[tdfp_pkg::E_BAD_SCHEMA],
                 sb.end_counts[tdfp_pkg::E_BAD_TYPE], sb.end_counts[tdfp_pkg::E_TRAILING]);
        if (sb.n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/tdfp_pkg.sv
sv/tdfp_core.sv
sv/tdfp_obuf.sv
sv/tagged_datagram_field_parser.sv
sv/tdfp_checker.sv
verif/tdfp_scoreboard_pkg.sv
verif/tagged_datagram_field_parser_test.sv
